[rtl/core/czp_pkg.sv]
`default_nettype none
package czp_pkg;

    // Field widths and fixed-point format.
    localparam int COORD_BITS = 14;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int ZOOM_FRAC  = 16;
    localparam int ZOOM_BITS  = ZOOM_FRAC + 1;
    localparam int ACC_BITS   = COORD_BITS + 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [SIZE_BITS-1:0]  size_t;
    typedef logic        [ZOOM_BITS-1:0]  zoom_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;

    localparam zoom_t ZOOM_ONE = zoom_t'(1) << ZOOM_FRAC;

    // Command codes.
    localparam logic [3:0] F_ZIN   = 4'd0;
    localparam logic [3:0] F_ZOUT  = 4'd1;
    localparam logic [3:0] F_LEFT  = 4'd2;
    localparam logic [3:0] F_RIGHT = 4'd3;
    localparam logic [3:0] F_UP    = 4'd4;
    localparam logic [3:0] F_DOWN  = 4'd5;
    localparam logic [3:0] F_SET   = 4'd6;
    localparam logic [3:0] F_CORR  = 4'd7;
    localparam logic [3:0] F_FON   = 4'd8;
    localparam logic [3:0] F_FOFF  = 4'd9;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZOOM_REF  = 2'd1;
    localparam logic [1:0] ST_MOVE_REF  = 2'd2;

    // Register indexes.
    localparam logic [2:0] R_FRAME_W  = 3'd0;
    localparam logic [2:0] R_FRAME_H  = 3'd1;
    localparam logic [2:0] R_ZOOM_MIN = 3'd2;
    localparam logic [2:0] R_ZOOM_MAX = 3'd3;
    localparam logic [2:0] R_ZOOM_STP = 3'd4;
    localparam logic [2:0] R_PAN_STP  = 3'd5;

    // Scale unit request.
    typedef struct packed {
        logic  en;
        zoom_t z;
        size_t len;
    } mul_req_t;

    // Divider request and response.
    typedef struct packed {
        logic  start;
        size_t num;
        size_t den;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        zoom_t q;
    } div_rsp_t;

endpackage
`default_nettype wire

[rtl/core/czp_mul.sv]
`default_nettype none
module czp_mul (
    input  wire logic              aclk,
    input  wire czp_pkg::mul_req_t req,
    output czp_pkg::size_t         q
);
    import czp_pkg::*;

    localparam int PROD_BITS = ZOOM_BITS + SIZE_BITS;

    logic [PROD_BITS-1:0] prod;
    size_t                q_reg;

    // Size from zoom fraction: floor(z * len / 2^ZOOM_FRAC).
    assign prod = {{SIZE_BITS{1'b0}}, req.z} * {{ZOOM_BITS{1'b0}}, req.len};

    always_ff @(posedge aclk) begin
        if (req.en) begin
            q_reg <= prod[ZOOM_FRAC +: SIZE_BITS];
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

[rtl/core/czp_div.sv]
`default_nettype none
module czp_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire czp_pkg::div_req_t req,
    output czp_pkg::div_rsp_t      rsp
);
    import czp_pkg::*;

    localparam int CNT_BITS = $clog2(ZOOM_BITS + 1);

    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    size_t               rem_reg, rem_next;
    size_t               den_reg, den_next;
    zoom_t               q_reg, q_next;
    logic [SIZE_BITS:0]  rem_sh;
    logic                ge;

    // One quotient bit per cycle; the numerator is below the divisor,
    // so the remainder starts as the numerator and zeros shift in.
    assign rem_sh = {rem_reg, 1'b0};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        q_next   = q_reg;
        if (req.start) begin
            cnt_next = CNT_BITS'(ZOOM_BITS);
            rem_next = req.num;
            den_next = req.den;
            q_next   = '0;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (ge) begin
                rem_next = size_t'(rem_sh - {1'b0, den_reg});
            end else begin
                rem_next = rem_sh[SIZE_BITS-1:0];
            end
            q_next = {q_reg[ZOOM_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.busy = cnt_reg != '0;
    assign rsp.q    = q_reg;

endmodule
`default_nettype wire

[rtl/core/crop_window_zoom_pan_controller.sv]
`default_nettype none
// Channel   Direction  Ports                                Contents
// command   in         s_tvalid s_tready s_tdata s_tuser    one command transaction
// result    out        m_tvalid m_tready m_tdata            status and crop window
// config    in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// A pan or query runs S_CMD, S_OUTGO and S_OUT (fixed mode adds S_MW and S_MH);
// a zoom with recentering also runs the scale and divider states: a shared scale
// multiplier registers each size, and a shared divider forms both corrected zooms.
// Reset is synchronous on aresetn low and loads the default frame and window.
// The block takes no command while one is in flight; a finished result waits in
// the output register while the next command is already accepted and worked on.
module crop_window_zoom_pan_controller (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, zoom_request, offset_dx, offset_dy
    input  wire logic [79:0]  s_tdata,
    // func
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, out_x, out_y, out_w, out_h, zoom_now, zoom_corrected,
    // fixed_on, centre_x, centre_y
    output logic [119:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [16:0]  cfg_data
);
    import czp_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CMD   = 4'd1;
    localparam logic [3:0] S_MW    = 4'd2;
    localparam logic [3:0] S_MH    = 4'd3;
    localparam logic [3:0] S_APPLY = 4'd4;
    localparam logic [3:0] S_WX    = 4'd5;
    localparam logic [3:0] S_WY    = 4'd6;
    localparam logic [3:0] S_RCCHK = 4'd7;
    localparam logic [3:0] S_DIVX  = 4'd8;
    localparam logic [3:0] S_DIVY  = 4'd9;
    localparam logic [3:0] S_RCFIN = 4'd10;
    localparam logic [3:0] S_OUTGO = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam logic [1:0] PH_CMD = 2'd0;
    localparam logic [1:0] PH_RC  = 2'd1;
    localparam logic [1:0] PH_OUT = 2'd2;

    localparam size_t  RST_W  = size_t'(1920);
    localparam size_t  RST_H  = size_t'(1080);
    localparam coord_t RST_AX = coord_t'(960);
    localparam coord_t RST_AY = coord_t'(540);

    typedef struct packed {
        logic   ok;
        coord_t pos;
        size_t  len;
        coord_t anc;
    } widen_t;

    function automatic acc_t sx(input coord_t v);
        return acc_t'(v);
    endfunction

    function automatic acc_t ux(input size_t v);
        return $signed({{(ACC_BITS-SIZE_BITS){1'b0}}, v});
    endfunction

    function automatic zoom_t zsat(input zoom_t v);
        return (v > ZOOM_ONE) ? ZOOM_ONE : v;
    endfunction

    // One axis of a zoom out.
    function automatic widen_t widen(input coord_t pos, input size_t len,
                                     input coord_t anc, input size_t nlen,
                                     input size_t full, input logic fixed);
        widen_t r;
        acc_t   d;
        acc_t   hd;
        acc_t   p;
        acc_t   np;
        logic   edge_hit;
        d  = ux(nlen) - ux(len);
        hd = (d + $signed({{(ACC_BITS-1){1'b0}}, d[ACC_BITS-1]})) >>> 1;
        p  = sx(pos);
        edge_hit = (p == '0) || (p + ux(len) == ux(full)) ||
                   (p - hd < 0) || (p + ux(nlen) > ux(full));
        r.ok  = 1'b1;
        r.pos = pos;
        r.len = nlen;
        r.anc = anc;
        if (edge_hit) begin
            if (fixed) begin
                r.ok  = 1'b0;
                r.len = len;
            end else begin
                if (p == '0) begin
                    np = p;
                end else if (p + ux(len) == ux(full)) begin
                    np = p - d;
                end else if (p - hd < 0) begin
                    np = '0;
                end else begin
                    np = ux(full) - ux(nlen);
                end
                r.pos = np[COORD_BITS-1:0];
                r.anc = coord_t'(sx(r.pos) + ux(nlen >> 1));
            end
        end else begin
            r.pos = coord_t'(sx(anc) - ux(nlen >> 1));
        end
        return r;
    endfunction

    // Configuration registers.
    size_t fw_reg, fh_reg, pan_reg;
    zoom_t zmin_reg, zmax_reg, zstep_reg;

    // Window state.
    coord_t cl_reg, cl_next, ct_reg, ct_next;
    size_t  cw_reg, cw_next, ch_reg, ch_next;
    zoom_t  zl_reg, zl_next, fz_reg, fz_next;
    coord_t ax_reg, ax_next, ay_reg, ay_next;
    coord_t fax_reg, fax_next, fay_reg, fay_next;
    coord_t hdx_reg, hdx_next, hdy_reg, hdy_next;
    logic   fix_reg, fix_next;

    // Sequencer and scratch.
    logic [3:0] state_reg, state_next;
    logic [1:0] ph_reg, ph_next;
    logic [3:0] op_reg, op_next;
    logic [1:0] st_reg, st_next;
    coord_t     px_in_reg, py_in_reg, dx_in_reg, dy_in_reg;
    zoom_t      zr_in_reg;
    zoom_t      mz_reg, mz_next;
    size_t      sw_reg, sw_next;
    coord_t     cx_reg, cx_next, cy_reg, cy_next;
    size_t      ayv_reg, ayv_next;
    zoom_t      pq_reg, pq_next;

    logic         m_valid_reg, m_valid_next;
    logic [119:0] m_data_reg, m_data_next;

    mul_req_t mreq;
    size_t    mq;
    div_req_t dreq;
    div_rsp_t drsp;

    // Combinational scratch.
    logic signed [ZOOM_BITS+1:0] zdiff;
    logic [ZOOM_BITS:0]          zsum;
    zoom_t                       zin_new;
    widen_t                      wr;
    acc_t                        rcx, rcy, hw, hh, axv, ayv;
    logic                        in_frame, rc_neg;
    zoom_t                       pmin;
    size_t                       ow, oh;
    coord_t                      ox, oy;
    logic                        out_free;

    czp_mul u_mul (
        .aclk (aclk),
        .req  (mreq),
        .q    (mq)
    );

    czp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg    <= RST_W;
            fh_reg    <= RST_H;
            zmin_reg  <= zoom_t'(6554);
            zmax_reg  <= ZOOM_ONE;
            zstep_reg <= zoom_t'(6554);
            pan_reg   <= size_t'(10);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                R_FRAME_W:  fw_reg <= (cfg_data[SIZE_BITS-1:0] == '0) ? size_t'(1)
                                      : cfg_data[SIZE_BITS-1:0];
                R_FRAME_H:  fh_reg <= (cfg_data[SIZE_BITS-1:0] == '0) ? size_t'(1)
                                      : cfg_data[SIZE_BITS-1:0];
                R_ZOOM_MIN: zmin_reg  <= zsat(cfg_data);
                R_ZOOM_MAX: zmax_reg  <= zsat(cfg_data);
                R_ZOOM_STP: zstep_reg <= zsat(cfg_data);
                R_PAN_STP:  pan_reg   <= cfg_data[SIZE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        cl_next = cl_reg;   ct_next = ct_reg;   cw_next = cw_reg;   ch_next = ch_reg;
        zl_next = zl_reg;   fz_next = fz_reg;   ax_next = ax_reg;   ay_next = ay_reg;
        fax_next = fax_reg; fay_next = fay_reg; hdx_next = hdx_reg; hdy_next = hdy_reg;
        fix_next = fix_reg;
        state_next = state_reg;
        ph_next  = ph_reg;
        op_next  = op_reg;
        st_next  = st_reg;
        mz_next  = mz_reg;
        sw_next  = sw_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        ayv_next = ayv_reg;
        pq_next  = pq_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        mreq = '0;
        dreq = '0;
        dreq.den = fw_reg;

        zdiff   = $signed({2'b00, zl_reg}) - $signed({2'b00, zstep_reg});
        zsum    = {1'b0, zl_reg} + {1'b0, zstep_reg};
        zin_new = (zdiff < $signed({2'b00, zmin_reg})) ? zmin_reg
                  : zdiff[ZOOM_BITS-1:0];

        wr = widen(cl_reg, cw_reg, ax_reg, sw_reg, fw_reg, fix_reg);

        rcx = sx(ax_reg) - sx(hdx_reg);
        rcy = sx(ay_reg) - sx(hdy_reg);
        hw  = ux(sw_reg >> 1);
        hh  = ux(mq >> 1);
        in_frame = (rcx + hw <= ux(fw_reg)) && (rcx - hw >= 0) &&
                   (rcy + hh <= ux(fh_reg)) && (rcy - hh >= 0);
        if (rcx + hw > ux(fw_reg)) begin
            axv = ux(fw_reg) - rcx;
        end else if (rcx - hw < 0) begin
            axv = rcx;
        end else begin
            axv = hw;
        end
        if (rcy + hh > ux(fh_reg)) begin
            ayv = ux(fh_reg) - rcy;
        end else if (rcy - hh < 0) begin
            ayv = rcy;
        end else begin
            ayv = hh;
        end
        rc_neg = (axv <= 0) || (ayv <= 0);
        pmin   = (pq_reg < drsp.q) ? pq_reg : drsp.q;

        if (fix_reg) begin
            ow = sw_reg;
            oh = mq;
            ox = coord_t'(sx(fax_reg) - ux(sw_reg >> 1));
            oy = coord_t'(sx(fay_reg) - ux(mq >> 1));
        end else begin
            ow = cw_reg;
            oh = ch_reg;
            ox = cl_reg;
            oy = ct_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    st_next    = ST_OK;
                    state_next = S_CMD;
                end
            end

            S_CMD: begin
                state_next = S_OUTGO;
                ph_next    = PH_CMD;
                unique case (op_reg)
                    F_ZIN: begin
                        if (zl_reg == zmin_reg) begin
                            st_next = ST_ZOOM_REF;
                        end else begin
                            zl_next    = zin_new;
                            mz_next    = zin_new;
                            state_next = S_MW;
                        end
                    end
                    F_ZOUT: begin
                        if (zl_reg == zmax_reg) begin
                            st_next = ST_ZOOM_REF;
                        end else if (zsum > {1'b0, zmax_reg}) begin
                            if (fix_reg && ((sx(ax_reg) != ux(fw_reg >> 1)) ||
                                            (sx(ay_reg) != ux(fh_reg >> 1)))) begin
                                st_next = ST_ZOOM_REF;
                            end else begin
                                zl_next = zmax_reg;
                                cl_next = '0;
                                ct_next = '0;
                                cw_next = fw_reg;
                                ch_next = fh_reg;
                                if (fix_reg) begin
                                    ph_next    = PH_RC;
                                    state_next = S_MW;
                                end
                            end
                        end else begin
                            mz_next    = zsum[ZOOM_BITS-1:0];
                            state_next = S_MW;
                        end
                    end
                    F_LEFT: begin
                        if (fix_reg || (sx(cl_reg) - ux(pan_reg) < 0)) begin
                            st_next = ST_MOVE_REF;
                        end else begin
                            cl_next = coord_t'(sx(cl_reg) - ux(pan_reg));
                            ax_next = coord_t'(sx(ax_reg) - ux(pan_reg));
                        end
                    end
                    F_RIGHT: begin
                        if (fix_reg ||
                            (sx(cl_reg) + ux(cw_reg) + ux(pan_reg) > ux(fw_reg))) begin
                            st_next = ST_MOVE_REF;
                        end else begin
                            cl_next = coord_t'(sx(cl_reg) + ux(pan_reg));
                            ax_next = coord_t'(sx(ax_reg) + ux(pan_reg));
                        end
                    end
                    F_UP: begin
                        if (fix_reg || (sx(ct_reg) - ux(pan_reg) < 0)) begin
                            st_next = ST_MOVE_REF;
                        end else begin
                            ct_next = coord_t'(sx(ct_reg) - ux(pan_reg));
                            ay_next = coord_t'(sx(ay_reg) - ux(pan_reg));
                        end
                    end
                    F_DOWN: begin
                        if (fix_reg ||
                            (sx(ct_reg) + ux(ch_reg) + ux(pan_reg) > ux(fh_reg))) begin
                            st_next = ST_MOVE_REF;
                        end else begin
                            ct_next = coord_t'(sx(ct_reg) + ux(pan_reg));
                            ay_next = coord_t'(sx(ay_reg) + ux(pan_reg));
                        end
                    end
                    F_SET: begin
                        zl_next    = zsat(zr_in_reg);
                        mz_next    = zsat(zr_in_reg);
                        ax_next    = px_in_reg;
                        ay_next    = py_in_reg;
                        fix_next   = 1'b1;
                        state_next = S_MW;
                    end
                    F_CORR: begin
                        hdx_next = dx_in_reg;
                        hdy_next = dy_in_reg;
                        if (fix_reg) begin
                            ph_next    = PH_RC;
                            state_next = S_MW;
                        end
                    end
                    F_FON: begin
                        fix_next   = 1'b1;
                        ph_next    = PH_RC;
                        state_next = S_MW;
                    end
                    F_FOFF: begin
                        fix_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            // Width then height through the shared scale unit.
            S_MW: begin
                mreq.en  = 1'b1;
                mreq.len = fw_reg;
                unique case (ph_reg)
                    PH_RC:   mreq.z = zl_reg;
                    PH_OUT:  mreq.z = fz_reg;
                    default: mreq.z = mz_reg;
                endcase
                state_next = S_MH;
            end

            S_MH: begin
                mreq.en  = 1'b1;
                mreq.len = fh_reg;
                unique case (ph_reg)
                    PH_RC:   mreq.z = zl_reg;
                    PH_OUT:  mreq.z = fz_reg;
                    default: mreq.z = mz_reg;
                endcase
                sw_next = mq;
                unique case (ph_reg)
                    PH_RC:   state_next = S_RCCHK;
                    PH_OUT:  state_next = S_OUT;
                    default: state_next = (op_reg == F_ZOUT) ? S_WX : S_APPLY;
                endcase
            end

            // New window around the anchor for zoom in and set centre.
            S_APPLY: begin
                cw_next = sw_reg;
                ch_next = mq;
                cl_next = coord_t'(sx(ax_reg) - ux(sw_reg >> 1));
                ct_next = coord_t'(sx(ay_reg) - ux(mq >> 1));
                if ((op_reg == F_ZIN) && fix_reg) begin
                    ph_next    = PH_RC;
                    state_next = S_MW;
                end else begin
                    state_next = S_OUTGO;
                end
            end

            S_WX: begin
                if (!wr.ok) begin
                    st_next    = ST_ZOOM_REF;
                    state_next = S_OUTGO;
                end else begin
                    cl_next    = wr.pos;
                    cw_next    = wr.len;
                    ax_next    = wr.anc;
                    state_next = S_WY;
                end
            end

            S_WY: begin
                wr = widen(ct_reg, ch_reg, ay_reg, mq, fh_reg, fix_reg);
                if (!wr.ok) begin
                    st_next    = ST_ZOOM_REF;
                    state_next = S_OUTGO;
                end else begin
                    ct_next = wr.pos;
                    ch_next = wr.len;
                    ay_next = wr.anc;
                    zl_next = mz_reg;
                    if (fix_reg) begin
                        ph_next    = PH_RC;
                        state_next = S_MW;
                    end else begin
                        state_next = S_OUTGO;
                    end
                end
            end

            // Corrected centre; shrink the zoom when the window leaves the frame.
            S_RCCHK: begin
                cx_next  = rcx[COORD_BITS-1:0];
                cy_next  = rcy[COORD_BITS-1:0];
                ayv_next = ayv[SIZE_BITS-1:0];
                if (in_frame) begin
                    fax_next   = rcx[COORD_BITS-1:0];
                    fay_next   = rcy[COORD_BITS-1:0];
                    fz_next    = zl_reg;
                    state_next = S_OUTGO;
                end else if (rc_neg) begin
                    state_next = S_OUTGO;
                end else begin
                    dreq.start = 1'b1;
                    dreq.num   = axv[SIZE_BITS-1:0];
                    dreq.den   = fw_reg;
                    state_next = S_DIVX;
                end
            end

            S_DIVX: begin
                if (!drsp.busy) begin
                    pq_next    = drsp.q;
                    dreq.start = 1'b1;
                    dreq.num   = ayv_reg;
                    dreq.den   = fh_reg;
                    state_next = S_DIVY;
                end
            end

            S_DIVY: begin
                if (!drsp.busy) begin
                    state_next = S_RCFIN;
                end
            end

            S_RCFIN: begin
                if (pmin > zmin_reg) begin
                    fax_next = cx_reg;
                    fay_next = cy_reg;
                    fz_next  = pmin;
                end
                state_next = S_OUTGO;
            end

            S_OUTGO: begin
                if (fix_reg) begin
                    ph_next    = PH_OUT;
                    state_next = S_MW;
                end else begin
                    state_next = S_OUT;
                end
            end

            // Result transaction into the output register.
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, ay_reg, ax_reg, fix_reg, fz_reg, zl_reg,
                                    oh, ow, oy, ox, st_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Command payload capture, scratch registers and result data.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            px_in_reg <= s_tdata[13:0];
            py_in_reg <= s_tdata[27:14];
            zr_in_reg <= s_tdata[44:28];
            dx_in_reg <= s_tdata[58:45];
            dy_in_reg <= s_tdata[72:59];
        end
        mz_reg     <= mz_next;
        sw_reg     <= sw_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        ayv_reg    <= ayv_next;
        pq_reg     <= pq_next;
        m_data_reg <= m_data_next;
        op_reg     <= op_next;
        st_reg     <= st_next;
    end

    // Control and window state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ph_reg      <= PH_CMD;
            m_valid_reg <= 1'b0;
            cl_reg  <= '0;
            ct_reg  <= '0;
            cw_reg  <= RST_W;
            ch_reg  <= RST_H;
            zl_reg  <= ZOOM_ONE;
            fz_reg  <= ZOOM_ONE;
            ax_reg  <= RST_AX;
            ay_reg  <= RST_AY;
            fax_reg <= RST_AX;
            fay_reg <= RST_AY;
            hdx_reg <= '0;
            hdy_reg <= '0;
            fix_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            m_valid_reg <= m_valid_next;
            cl_reg  <= cl_next;
            ct_reg  <= ct_next;
            cw_reg  <= cw_next;
            ch_reg  <= ch_next;
            zl_reg  <= zl_next;
            fz_reg  <= fz_next;
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            fax_reg <= fax_next;
            fay_reg <= fay_next;
            hdx_reg <= hdx_next;
            hdy_reg <= hdy_next;
            fix_reg <= fix_next;
        end
    end

endmodule
`default_nettype wire

[bench/crop_window_zoom_pan_controller_tb.sv]
`default_nettype none
module crop_window_zoom_pan_controller_tb;
    import czp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Command codes that the package does not name.
    localparam logic [3:0] F_QUERY     = 4'd10;
    localparam logic [3:0] F_SPARE_TOP = 4'd15;
    // Worst command latency plus margin, in cycles.
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic [3:0] func;
        coord_t     pos_x;
        coord_t     pos_y;
        zoom_t      zoom_req;
        coord_t     dx;
        coord_t     dy;
    } command_t;

    typedef struct {
        logic [1:0] status;
        coord_t     out_x;
        coord_t     out_y;
        size_t      out_w;
        size_t      out_h;
        zoom_t      zoom_now;
        zoom_t      zoom_corr;
        logic       fixed_on;
        coord_t     centre_x;
        coord_t     centre_y;
    } window_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [16:0]  cfg_data = '0;

    crop_window_zoom_pan_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the controller: configuration and window state.
    longint frame_w, frame_h, zmin, zmax, zstep, pstep;
    longint crop_x, crop_y, crop_w, crop_h, zoom_lvl;
    longint anchor_x, anchor_y, fix_x, fix_y, fix_zoom, corr_x, corr_y;
    bit     fixed_mode;

    command_t cmd_queue[$];
    window_t  window_q[$];
    command_t cmd_live;
    bit       cmd_taken = 1'b0;
    int       cmds_sent = 0;
    int       cmds_taken = 0;
    int       errors = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    bit       calm = 1'b0;
    bit       hold_off = 1'b0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic longint wrap_c(longint v);
        coord_t t;
        t = v[COORD_BITS-1:0];
        return t;
    endfunction

    function automatic longint wrap_s(longint v);
        return v & ((64'd1 << SIZE_BITS) - 1);
    endfunction

    function automatic longint wrap_z(longint v);
        return v & ((64'd1 << ZOOM_BITS) - 1);
    endfunction

    function automatic longint sat_zoom(logic [16:0] v);
        return (v > ZOOM_ONE) ? longint'(ZOOM_ONE) : longint'(v);
    endfunction

    function automatic longint scaled(longint z, longint len);
        return (z * len) >> ZOOM_FRAC;
    endfunction

    // Put the shadow back to its power-on values.
    function automatic void reset_shadow();
        frame_w = 1920; frame_h = 1080;
        zmin = 6554; zmax = ZOOM_ONE; zstep = 6554; pstep = 10;
        crop_x = 0; crop_y = 0; crop_w = 1920; crop_h = 1080;
        zoom_lvl = ZOOM_ONE; anchor_x = 960; anchor_y = 540;
        fix_x = 960; fix_y = 540; fix_zoom = ZOOM_ONE;
        corr_x = 0; corr_y = 0; fixed_mode = 1'b0;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [16:0] v);
        longint s;
        s = wrap_s(v);
        case (idx)
            R_FRAME_W:  frame_w = (s != 0) ? s : 1;
            R_FRAME_H:  frame_h = (s != 0) ? s : 1;
            R_ZOOM_MIN: zmin = sat_zoom(v);
            R_ZOOM_MAX: zmax = sat_zoom(v);
            R_ZOOM_STP: zstep = sat_zoom(v);
            R_PAN_STP:  pstep = s;
            default: ;
        endcase
    endfunction

    // Rebuild the corrected centre and zoom; shrink the zoom at the frame edge.
    function automatic void refit_fixed();
        longint cx, cy, w, h, ax, ay, px, py, p;
        cx = anchor_x - corr_x;
        cy = anchor_y - corr_y;
        w = scaled(zoom_lvl, frame_w);
        h = scaled(zoom_lvl, frame_h);
        ax = w / 2;
        ay = h / 2;
        if (cx + w / 2 <= frame_w && cx - w / 2 >= 0 &&
            cy + h / 2 <= frame_h && cy - h / 2 >= 0) begin
            fix_x = wrap_c(cx);
            fix_y = wrap_c(cy);
            fix_zoom = zoom_lvl;
            return;
        end
        if (cx + w / 2 > frame_w) ax = frame_w - cx;
        else if (cx - w / 2 < 0) ax = cx;
        if (cy + h / 2 > frame_h) ay = frame_h - cy;
        else if (cy - h / 2 < 0) ay = cy;
        px = (2 * ax * longint'(ZOOM_ONE)) / frame_w;
        py = (2 * ay * longint'(ZOOM_ONE)) / frame_h;
        p = (px < py) ? px : py;
        if (p > zmin) begin
            fix_x = wrap_c(cx);
            fix_y = wrap_c(cy);
            fix_zoom = wrap_z(p);
        end
    endfunction

    // Widen one axis for zoom out; returns 0 when fixed mode refuses it.
    function automatic bit widen_axis(inout longint pos, inout longint len,
                                      inout longint anc, input longint nlen,
                                      input longint full);
        longint d;
        d = nlen - len;
        if (pos == 0 || pos + len == full || pos - d / 2 < 0 || pos + nlen > full) begin
            if (fixed_mode) return 1'b0;
            if (pos != 0) begin
                if (pos + len == full) pos = pos - d;
                else if (pos - d / 2 < 0) pos = 0;
                else pos = full - nlen;
            end
            pos = wrap_c(pos);
            len = wrap_s(nlen);
            anc = wrap_c(pos + len / 2);
        end else begin
            len = wrap_s(nlen);
            pos = wrap_c(anc - len / 2);
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] zoom_in_step();
        if (zoom_lvl == zmin) return ST_ZOOM_REF;
        zoom_lvl = (zoom_lvl - zstep < zmin) ? zmin : zoom_lvl - zstep;
        crop_w = wrap_s(scaled(zoom_lvl, frame_w));
        crop_h = wrap_s(scaled(zoom_lvl, frame_h));
        crop_x = wrap_c(anchor_x - crop_w / 2);
        crop_y = wrap_c(anchor_y - crop_h / 2);
        if (fixed_mode) refit_fixed();
        return ST_OK;
    endfunction

    function automatic logic [1:0] zoom_out_step();
        longint nz;
        if (zoom_lvl == zmax) return ST_ZOOM_REF;
        if (zoom_lvl + zstep > zmax) begin
            if (fixed_mode && (anchor_x != frame_w / 2 || anchor_y != frame_h / 2))
                return ST_ZOOM_REF;
            zoom_lvl = zmax;
            crop_x = 0;
            crop_y = 0;
            crop_w = wrap_s(frame_w);
            crop_h = wrap_s(frame_h);
        end else begin
            nz = zoom_lvl + zstep;
            if (!widen_axis(crop_x, crop_w, anchor_x, scaled(nz, frame_w), frame_w))
                return ST_ZOOM_REF;
            if (!widen_axis(crop_y, crop_h, anchor_y, scaled(nz, frame_h), frame_h))
                return ST_ZOOM_REF;
            zoom_lvl = wrap_z(nz);
        end
        if (fixed_mode) refit_fixed();
        return ST_OK;
    endfunction

    // Apply one command to the shadow and return the window it reports.
    function automatic window_t predict_window(command_t c);
        window_t r;
        longint ow, oh;
        r.status = ST_OK;
        case (c.func)
            F_ZIN:  r.status = zoom_in_step();
            F_ZOUT: r.status = zoom_out_step();
            F_LEFT: begin
                if (fixed_mode || crop_x - pstep < 0) r.status = ST_MOVE_REF;
                else begin
                    crop_x = wrap_c(crop_x - pstep);
                    anchor_x = wrap_c(anchor_x - pstep);
                end
            end
            F_RIGHT: begin
                if (fixed_mode || crop_x + crop_w + pstep > frame_w) r.status = ST_MOVE_REF;
                else begin
                    crop_x = wrap_c(crop_x + pstep);
                    anchor_x = wrap_c(anchor_x + pstep);
                end
            end
            F_UP: begin
                if (fixed_mode || crop_y - pstep < 0) r.status = ST_MOVE_REF;
                else begin
                    crop_y = wrap_c(crop_y - pstep);
                    anchor_y = wrap_c(anchor_y - pstep);
                end
            end
            F_DOWN: begin
                if (fixed_mode || crop_y + crop_h + pstep > frame_h) r.status = ST_MOVE_REF;
                else begin
                    crop_y = wrap_c(crop_y + pstep);
                    anchor_y = wrap_c(anchor_y + pstep);
                end
            end
            F_SET: begin
                zoom_lvl = sat_zoom(c.zoom_req);
                anchor_x = c.pos_x;
                anchor_y = c.pos_y;
                crop_w = wrap_s(scaled(zoom_lvl, frame_w));
                crop_h = wrap_s(scaled(zoom_lvl, frame_h));
                crop_x = wrap_c(anchor_x - crop_w / 2);
                crop_y = wrap_c(anchor_y - crop_h / 2);
                fixed_mode = 1'b1;
            end
            F_CORR: begin
                corr_x = c.dx;
                corr_y = c.dy;
                if (fixed_mode) refit_fixed();
            end
            F_FON: begin
                fixed_mode = 1'b1;
                refit_fixed();
            end
            F_FOFF: fixed_mode = 1'b0;
            default: ;
        endcase
        if (fixed_mode) begin
            ow = wrap_s(scaled(fix_zoom, frame_w));
            oh = wrap_s(scaled(fix_zoom, frame_h));
            r.out_x = fix_x - ow / 2;
            r.out_y = fix_y - oh / 2;
        end else begin
            ow = crop_w;
            oh = crop_h;
            r.out_x = crop_x;
            r.out_y = crop_y;
        end
        r.out_w = ow;
        r.out_h = oh;
        r.zoom_now = zoom_lvl;
        r.zoom_corr = fix_zoom;
        r.fixed_on = fixed_mode;
        r.centre_x = anchor_x;
        r.centre_y = anchor_y;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 cmds_taken - window_q.size(), field, got, want);
    endtask

    task automatic push_cmd(logic [3:0] f, coord_t px, coord_t py, zoom_t z,
                            coord_t dx, coord_t dy);
        command_t c;
        c.func = f; c.pos_x = px; c.pos_y = py; c.zoom_req = z; c.dx = dx; c.dy = dy;
        cmd_queue.push_back(c);
    endtask

    // Random command: mostly sensible positions and zooms, some raw values.
    task automatic push_random_cmd();
        logic [3:0] f;
        coord_t px, py, dx, dy;
        zoom_t  z;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) f = $urandom_range(F_QUERY + 1, F_SPARE_TOP);
        else if (pick < 30) f = $urandom_range(F_ZIN, F_ZOUT);
        else if (pick < 60) f = $urandom_range(F_LEFT, F_DOWN);
        else if (pick < 70) f = F_FOFF;
        else f = $urandom_range(F_SET, F_QUERY);
        if ($urandom_range(0, 9) == 0) begin
            px = $urandom; py = $urandom; z = $urandom; dx = $urandom; dy = $urandom;
        end else begin
            px = $urandom_range(0, frame_w);
            py = $urandom_range(0, frame_h);
            z  = $urandom_range(zmin, ZOOM_ONE);
            dx = $urandom_range(0, 80) - 40;
            dy = $urandom_range(0, 80) - 40;
        end
        push_cmd(f, px, py, z, dx, dy);
    endtask

    // Write one register; cfg_valid is lowered by the caller after the batch.
    task automatic write_reg(logic [2:0] idx, logic [16:0] v);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, v);
    endtask

    task automatic configure(logic [16:0] fw, logic [16:0] fh, logic [16:0] zlo,
                             logic [16:0] zhi, logic [16:0] zst, logic [16:0] pst);
        write_reg(R_FRAME_W, fw);
        write_reg(R_FRAME_H, fh);
        write_reg(R_ZOOM_MIN, zlo);
        write_reg(R_ZOOM_MAX, zhi);
        write_reg(R_ZOOM_STP, zst);
        write_reg(R_PAN_STP, pst);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (cmd_queue.size() == 0 && cmds_taken == cmds_sent && window_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Command driver: inputs change on the falling edge only.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || cmd_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                cmd_live = cmd_queue.pop_front();
                s_tdata <= {7'd0, cmd_live.dy, cmd_live.dx, cmd_live.zoom_req,
                            cmd_live.pos_y, cmd_live.pos_x};
                s_tuser <= cmd_live.func;
                s_tvalid <= 1'b1;
                cmds_sent++;
                if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
            end else begin
                s_tvalid <= 1'b0;
            end
            cmd_taken = 1'b0;
        end
    end

    // Command acceptance: each transaction updates the shadow.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready && !cmd_taken) begin
            window_q.push_back(predict_window(cmd_live));
            cmds_taken++;
            cmd_taken = 1'b1;
        end
    end

    // Result receiver backpressure.
    always @(negedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
        end
    end

    // Long receiver hold-off so that the block fills and stalls its input.
    initial begin
        wait (cmds_taken >= 200);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Result checker.
    always @(posedge aclk) begin
        window_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (window_q.size() == 0) begin
                errors++;
                $display("result with no command outstanding");
            end else begin
                w = window_q.pop_front();
                if (m_tdata[1:0] !== w.status) report_mismatch("status", m_tdata[1:0], w.status);
                if (m_tdata[15:2] !== w.out_x)
                    report_mismatch("out_x", coord_t'(m_tdata[15:2]), w.out_x);
                if (m_tdata[29:16] !== w.out_y)
                    report_mismatch("out_y", coord_t'(m_tdata[29:16]), w.out_y);
                if (m_tdata[42:30] !== w.out_w) report_mismatch("out_w", m_tdata[42:30], w.out_w);
                if (m_tdata[55:43] !== w.out_h) report_mismatch("out_h", m_tdata[55:43], w.out_h);
                if (m_tdata[72:56] !== w.zoom_now)
                    report_mismatch("zoom_now", m_tdata[72:56], w.zoom_now);
                if (m_tdata[89:73] !== w.zoom_corr)
                    report_mismatch("zoom_corrected", m_tdata[89:73], w.zoom_corr);
                if (m_tdata[90] !== w.fixed_on)
                    report_mismatch("fixed_on", m_tdata[90], w.fixed_on);
                if (m_tdata[104:91] !== w.centre_x)
                    report_mismatch("centre_x", coord_t'(m_tdata[104:91]), w.centre_x);
                if (m_tdata[118:105] !== w.centre_y)
                    report_mismatch("centre_y", coord_t'(m_tdata[118:105]), w.centre_y);
            end
        end
    end

    // Stimulus sequence.
    initial begin
        reset_shadow();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed commands at the default frame.
        push_cmd(F_QUERY, 0, 0, 0, 0, 0);
        push_cmd(F_ZOUT, 0, 0, 0, 0, 0);            // already full frame
        push_cmd(F_LEFT, 0, 0, 0, 0, 0);            // pan past the edge
        push_cmd(F_ZIN, 0, 0, 0, 0, 0);
        push_cmd(F_LEFT, 0, 0, 0, 0, 0);
        push_cmd(F_RIGHT, 0, 0, 0, 0, 0);
        push_cmd(F_UP, 0, 0, 0, 0, 0);
        push_cmd(F_DOWN, 0, 0, 0, 0, 0);
        push_cmd(F_ZOUT, 0, 0, 0, 0, 0);            // zoom out across an edge
        for (int i = 0; i < 10; i++) push_cmd(F_ZIN, 0, 0, 0, 0, 0);  // reach zoom_min
        push_cmd(F_QUERY + 1, -14'sd1, 14'sd1, 17'h1FFFF, -14'sd1, -14'sd1);
        push_cmd(F_SPARE_TOP, 0, 0, 0, 0, 0);
        push_cmd(F_SET, 14'sd8191, -14'sd8192, 17'h1FFFF, 0, 0);
        push_cmd(F_LEFT, 0, 0, 0, 0, 0);            // refused in fixed mode
        push_cmd(F_CORR, 0, 0, 0, 14'sd8191, -14'sd8192);
        push_cmd(F_SET, 14'sd100, 14'sd540, 17'd30000, 0, 0);
        push_cmd(F_CORR, 0, 0, 0, 14'sd30, -14'sd20);
        push_cmd(F_FON, 0, 0, 0, 0, 0);             // shrink at the edge
        push_cmd(F_ZOUT, 0, 0, 0, 0, 0);            // refused at edge in fixed mode
        push_cmd(F_FOFF, 0, 0, 0, 0, 0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(1920, 1080, 6554, 65536, 6554, 10);
                1: configure(1, 1, 0, 65536, 65536, 1);
                2: configure(8191, 8191, 0, 65536, 1, 8191);
                3: configure(640, 480, 3277, 65536, 3277, 1);
                4: configure(0, 17'h1E000, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 0);
                5: configure(17'h1F0F0, 8191, 65536, 0, 20000, 17'h1FFFF);
                6: configure(1000, 700, 13107, 52429, 9000, 37);
                default: configure(1920, 1080, 1000, 65536, 2000, 3);
            endcase
            for (int i = 0; i < 190; i++) push_random_cmd();
            if (phase == 7) wait (cmd_queue.size() < 80);
            if (phase == 7) calm = 1'b1;
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #15ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
